FILE: rtl/bldsw_pkg.sv
// ----------------------------------------------------------------------------
// bldsw_pkg
// Shared constants for the block-linear deswizzle address generator.
// ----------------------------------------------------------------------------
package bldsw_pkg;

  localparam int StrideW      = 15;
  localparam int HeightW      = 13;
  localparam int BlkLog2W     = 3;
  localparam int CfgDataW     = 15;
  localparam int CfgIdxW      = 2;
  localparam int AddrW        = 26;
  localparam int ChunkW       = 64;
  localparam int ChunkIdxW    = 5;
  localparam int GobRowW      = 5;
  localparam int InTdataW     = 128;
  localparam int OutTdataW    = 160;

  localparam int GobWidth     = 64;
  localparam int GobRows      = 8;
  localparam int MaxBlkLog2   = 5;

  localparam int DefMaxStrideBytes = 16384;
  localparam int DefMaxHeight      = 4096;

  localparam logic [StrideW-1:0]  StrideRst  = StrideW'(5120);
  localparam logic [HeightW-1:0]  HeightRst  = HeightW'(720);
  localparam logic [BlkLog2W-1:0] BlkLog2Rst = BlkLog2W'(4);

  typedef enum logic [CfgIdxW-1:0] {
    CfgStride  = 2'd0,
    CfgHeight  = 2'd1,
    CfgBlkLog2 = 2'd2
  } cfg_idx_e;

endpackage

FILE: rtl/block_linear_deswizzle_address.sv
// ----------------------------------------------------------------------------
// block_linear_deswizzle_address
// Maps a stream of 16-byte block-linear chunks to pitch-linear write beats.
// ----------------------------------------------------------------------------
// Each accepted input beat is registered and is presented as the output beat in the next cycle.
// Throughput: 1 beat per cycle; the output register takes a new beat whenever
// it is empty or being drained, the position counters advance on each beat.
// Reset: asynchronous active-low; counters cleared, output empty, config
// registers at stride 5120, height 720, block height log2 4.
module block_linear_deswizzle_address #(
  parameter int MAX_STRIDE_BYTES = bldsw_pkg::DefMaxStrideBytes,
  parameter int MAX_HEIGHT       = bldsw_pkg::DefMaxHeight
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bldsw_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bldsw_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [63:0] chunk_low, [127:64] chunk_high
  input  logic [bldsw_pkg::InTdataW-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [25:0] write_address, [89:26] write_low, [153:90] write_high, zero pad
  output logic [bldsw_pkg::OutTdataW-1:0]      m_axis_tdata,
  // [0] write_enable
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int ColCap  = MAX_STRIDE_BYTES / bldsw_pkg::GobWidth;
  localparam int RowCap  = (MAX_HEIGHT + bldsw_pkg::GobRows - 1) / bldsw_pkg::GobRows;
  localparam int ColW    = (ColCap > 1) ? $clog2(ColCap) : 1;
  localparam int RowW    = (RowCap > 1) ? $clog2(RowCap) : 1;
  localparam int ColClip = (ColCap > 511) ? 511 : ColCap;
  localparam int HgtClip = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
  localparam int YW      = RowW + 9;
  localparam int XW      = ColW + 6;
  localparam int PW      = YW + bldsw_pkg::StrideW;
  localparam int EW      = (YW > bldsw_pkg::HeightW) ? YW : bldsw_pkg::HeightW;
  localparam int AW      = bldsw_pkg::AddrW;
  localparam int CW      = bldsw_pkg::ChunkW;

  logic [bldsw_pkg::StrideW-1:0]  stride_q;
  logic [bldsw_pkg::HeightW-1:0]  height_q;
  logic [bldsw_pkg::BlkLog2W-1:0] blk_log2_q;

  logic [bldsw_pkg::ChunkIdxW-1:0] chunk_q, chunk_d;
  logic [bldsw_pkg::GobRowW-1:0]   gob_row_q, gob_row_d;
  logic [ColW-1:0]                 col_q, col_d;
  logic [RowW-1:0]                 row_q, row_d;

  logic                             out_valid_q;
  logic [AW-1:0]                    addr_q, addr_d;
  logic [CW-1:0]                    low_q, high_q;
  logic                             wen_q, wen_d;
  logic                             last_q, last_d;

  logic                             accept;
  logic [bldsw_pkg::BlkLog2W-1:0]   lg;
  logic [bldsw_pkg::HeightW-1:0]    eff_h;
  logic [8:0]                       bw_raw, bw_clip, bw_m1;
  logic [13:0]                      bh_sum, bh, bh_m1;
  logic [YW-1:0]                    gob_y, y_full;
  logic [XW-1:0]                    x_full;
  logic [PW-1:0]                    prod;
  logic [2:0]                       in_y;
  logic [5:0]                       in_x;
  logic                             last_chunk, last_gob, last_col, last_row;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q   <= bldsw_pkg::StrideRst;
      height_q   <= bldsw_pkg::HeightRst;
      blk_log2_q <= bldsw_pkg::BlkLog2Rst;
    end else if (cfg_we_i) begin
      case (bldsw_pkg::cfg_idx_e'(cfg_idx_i))
        bldsw_pkg::CfgStride:  stride_q   <= cfg_wdata_i[bldsw_pkg::StrideW-1:0];
        bldsw_pkg::CfgHeight:  height_q   <= cfg_wdata_i[bldsw_pkg::HeightW-1:0];
        bldsw_pkg::CfgBlkLog2: blk_log2_q <= cfg_wdata_i[bldsw_pkg::BlkLog2W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    lg = (blk_log2_q > bldsw_pkg::BlkLog2W'(bldsw_pkg::MaxBlkLog2))
         ? bldsw_pkg::BlkLog2W'(bldsw_pkg::MaxBlkLog2) : blk_log2_q;
    eff_h = (height_q > bldsw_pkg::HeightW'(HgtClip))
            ? bldsw_pkg::HeightW'(HgtClip) : height_q;

    bw_raw  = stride_q[bldsw_pkg::StrideW-1:6];
    bw_clip = (bw_raw > 9'(ColClip)) ? 9'(ColClip) : bw_raw;
    bw_m1   = (bw_clip == '0) ? '0 : bw_clip - 9'd1;

    bh_sum = 14'(eff_h) + (14'(bldsw_pkg::GobRows) << lg) - 14'd1;
    bh     = bh_sum >> (4'(lg) + 4'd3);
    bh_m1  = (bh == '0) ? '0 : bh - 14'd1;

    // intra-GOB swizzle
    in_y = {chunk_q[3:2], chunk_q[0]};
    in_x = {chunk_q[4], chunk_q[1], 4'b0000};

    gob_y  = (YW'(row_q) << (4'(lg) + 4'd3)) + (YW'(gob_row_q) << 3);
    y_full = gob_y + YW'(in_y);
    x_full = {col_q, in_x};
    prod   = PW'(y_full) * PW'(stride_q);
    addr_d = AW'(prod) + AW'(x_full);
    wen_d  = EW'(gob_y) < EW'(eff_h);

    last_chunk = chunk_q == '1;
    last_gob   = gob_row_q >= bldsw_pkg::GobRowW'((6'd1 << lg) - 6'd1);
    last_col   = 11'(col_q) >= 11'(bw_m1);
    last_row   = 14'(row_q) >= bh_m1;
    last_d     = last_chunk && last_gob && last_col && last_row;

    chunk_d   = chunk_q + 1'b1;
    gob_row_d = gob_row_q;
    col_d     = col_q;
    row_d     = row_q;
    if (last_chunk) begin
      if (!last_gob) begin
        gob_row_d = gob_row_q + 1'b1;
      end else begin
        gob_row_d = '0;
        if (!last_col) begin
          col_d = col_q + 1'b1;
        end else begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + 1'b1;
        end
      end
    end
  end

  // position counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= '0;
      gob_row_q   <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        chunk_q   <= chunk_d;
        gob_row_q <= gob_row_d;
        col_q     <= col_d;
        row_q     <= row_d;
      end
      if (s_axis_tready) begin
        out_valid_q <= s_axis_tvalid;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= addr_d;
      low_q  <= s_axis_tdata[CW-1:0];
      high_q <= s_axis_tdata[2*CW-1:CW];
      wen_q  <= wen_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bldsw_pkg::OutTdataW - AW - 2*CW){1'b0}}, high_q, low_q, addr_q};
  assign m_axis_tuser  = wen_q;
  assign m_axis_tlast  = last_q;

endmodule

FILE: dv/tb_block_linear_deswizzle_address.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_linear_deswizzle_address
// Checks the deswizzle address generator against an in-bench model of its
// GOB walk. Chunks go in over a stream port, and each output beat is compared
// with the predicted address, data, write enable and frame end. The run steps
// through register settings, including the clamped and degenerate ones, and
// varies stream back-pressure between phases.
// ----------------------------------------------------------------------------
module tb_block_linear_deswizzle_address;

  localparam int ChunksPerGob = 32;
  localparam int CycleLimit   = 200000;

  typedef struct packed {
    logic [bldsw_pkg::AddrW-1:0]  addr;
    logic [bldsw_pkg::ChunkW-1:0] lo;
    logic [bldsw_pkg::ChunkW-1:0] hi;
    logic                         we;
    logic                         fe;
  } pitch_write_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  bldsw_pkg::cfg_idx_e             cfg_idx_i = bldsw_pkg::CfgStride;
  logic [bldsw_pkg::CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bldsw_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bldsw_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;

  block_linear_deswizzle_address uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  logic [bldsw_pkg::InTdataW-1:0] chunk_q[$];
  pitch_write_t                   pending_writes[$];

  int unsigned reg_stride = 5120;
  int unsigned reg_height = 720;
  int unsigned reg_blk_log2 = 4;

  int unsigned pos_chunk = 0;
  int unsigned pos_gob = 0;
  int unsigned pos_col = 0;
  int unsigned pos_brow = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_beat = 1'b0;

  int cycles = 0;
  int err_count = 0;
  int chunks_in = 0;
  int writes_checked = 0;
  int frames_seen = 0;
  int suppressed_seen = 0;

  // Advance the GOB walk by one chunk and return the write it produces.
  function automatic pitch_write_t deswizzle_chunk(logic [bldsw_pkg::InTdataW-1:0] chunk);
    int unsigned       lg, gobs, bw, bh, eh, idx, in_y, in_x;
    longint unsigned   gob_y, gob_x, addr;
    bit                last_c, last_g, last_col, last_r;
    pitch_write_t      w;
    lg = (reg_blk_log2 > bldsw_pkg::MaxBlkLog2) ? bldsw_pkg::MaxBlkLog2 : reg_blk_log2;
    gobs = 1 << lg;
    eh = (reg_height > bldsw_pkg::DefMaxHeight) ? bldsw_pkg::DefMaxHeight : reg_height;
    bw = reg_stride >> 6;
    if (bw > (bldsw_pkg::DefMaxStrideBytes >> 6)) bw = bldsw_pkg::DefMaxStrideBytes >> 6;
    if (bw == 0) bw = 1;
    bh = (eh + (bldsw_pkg::GobRows << lg) - 1) >> (3 + lg);
    if (bh == 0) bh = 1;
    idx = pos_chunk & (ChunksPerGob - 1);
    gob_y = longint'(pos_brow) * (bldsw_pkg::GobRows << lg) + bldsw_pkg::GobRows * pos_gob;
    gob_x = longint'(bldsw_pkg::GobWidth) * pos_col;
    in_y = ((idx >> 1) & 'h06) | (idx & 1);
    in_x = ((idx << 3) & 'h10) | ((idx << 1) & 'h20);
    addr = (gob_y + in_y) * reg_stride + gob_x + in_x;
    last_c = idx >= ChunksPerGob - 1;
    last_g = pos_gob >= gobs - 1;
    last_col = pos_col >= bw - 1;
    last_r = pos_brow >= bh - 1;
    w.addr = addr[bldsw_pkg::AddrW-1:0];
    w.lo = chunk[bldsw_pkg::ChunkW-1:0];
    w.hi = chunk[2*bldsw_pkg::ChunkW-1:bldsw_pkg::ChunkW];
    w.we = gob_y < eh;
    w.fe = last_c && last_g && last_col && last_r;
    if (!last_c) begin
      pos_chunk = idx + 1;
    end else begin
      pos_chunk = 0;
      if (!last_g) begin
        pos_gob++;
      end else begin
        pos_gob = 0;
        if (!last_col) begin
          pos_col++;
        end else begin
          pos_col = 0;
          pos_brow = last_r ? 0 : pos_brow + 1;
        end
      end
    end
    return w;
  endfunction

  // driver: new beat or idle at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_beat)) begin
      if (chunk_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata  <= chunk_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk_i) begin
    pitch_write_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d writes outstanding", cycles,
               pending_writes.size());
      $display("== FAIL ==");
      $finish;
    end
    in_beat <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_writes.push_back(deswizzle_chunk(s_axis_tdata));
        chunks_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr = m_axis_tdata[bldsw_pkg::AddrW-1:0];
        got.lo   = m_axis_tdata[bldsw_pkg::AddrW +: bldsw_pkg::ChunkW];
        got.hi   = m_axis_tdata[bldsw_pkg::AddrW+bldsw_pkg::ChunkW +: bldsw_pkg::ChunkW];
        got.we   = m_axis_tuser;
        got.fe   = m_axis_tlast;
        if (pending_writes.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected beat: addr %h we %b last %b", got.addr, got.we, got.fe);
        end else begin
          want = pending_writes.pop_front();
          writes_checked++;
          if (want.fe) frames_seen++;
          if (!want.we) suppressed_seen++;
          if (got != want) begin
            err_count++;
            if (err_count <= 10)
              $display("write %0d mismatch: addr %h/%h lo %h/%h hi %h/%h we %b/%b last %b/%b",
                       writes_checked, want.addr, got.addr, want.lo, got.lo,
                       want.hi, got.hi, want.we, got.we, want.fe, got.fe);
          end
        end
      end
    end
  end

  task automatic drain();
    while (chunk_q.size() > 0 || s_axis_tvalid || pending_writes.size() > 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic push_random(int n);
    repeat (n) chunk_q.push_back({$urandom, $urandom, $urandom, $urandom});
  endtask

  task automatic run_phase(int unsigned stride, int unsigned height, int unsigned lg,
                           int n, int mode, bit hold);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= bldsw_pkg::CfgStride;
    cfg_wdata_i <= bldsw_pkg::CfgDataW'(stride);
    @(negedge clk_i);
    cfg_idx_i <= bldsw_pkg::CfgHeight;
    cfg_wdata_i <= bldsw_pkg::CfgDataW'(height);
    @(negedge clk_i);
    cfg_idx_i <= bldsw_pkg::CfgBlkLog2;
    cfg_wdata_i <= bldsw_pkg::CfgDataW'(lg);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_stride = stride & 'h7FFF;
    reg_height = height & 'h1FFF;
    reg_blk_log2 = lg & 'h7;
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
    push_random(n / 2);
    if (hold) drain();
    push_random(n - n / 2);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    // data extremes and walking bits at the reset settings
    chunk_q.push_back({64'h0, 64'h0});
    chunk_q.push_back({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
    chunk_q.push_back({64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
    chunk_q.push_back({64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
    for (int k = 0; k < 20; k++)
      chunk_q.push_back({64'd1 << (k * 3 + 1), ~(64'd1 << (k * 3))});
    run_phase(64, 8, 0, 100, 0, 1'b0);
    run_phase(0, 1, 0, 100, 1, 1'b1);
    run_phase(100, 20, 1, 120, 2, 1'b0);
    run_phase(128, 0, 7, 80, 3, 1'b0);
    run_phase(32767, 8191, 6, 80, 0, 1'b0);
    run_phase(64, 4096, 5, 80, 1, 1'b0);
    run_phase(16384, 4096, 0, 80, 2, 1'b0);
    run_phase(64, 1, 0, 100, 3, 1'b0);
    run_phase(128, 8, 1, 150, 0, 1'b0);
    run_phase(5120, 720, 4, 80, 1, 1'b0);
    run_phase(64, 8191, 3, 80, 2, 1'b0);
    for (int p = 0; p < 4; p++)
      run_phase($urandom_range(0, 512), $urandom_range(0, 64), $urandom_range(0, 7), 50,
                p + 3, 1'b0);
    drain();
    repeat (5) @(negedge clk_i);
    err_count += pending_writes.size();
    $display("%0d chunks in, %0d writes checked, %0d frame ends, %0d suppressed, %0d errors",
             chunks_in, writes_checked, frames_seen, suppressed_seen, err_count);
    $display("settings swept: narrow, clamped and odd strides, zero and clamped heights");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
